// ===== rtl/deaa_pkg.sv =====
package deaa_pkg;

  localparam int PixW = 32;

  typedef enum logic [1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_SUBPIXEL  = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_READ     = 5'b00010,
    ST_CALC     = 5'b00100,
    ST_STRENGTH = 5'b01000,
    ST_DIV      = 5'b10000
  } state_t;

  function automatic logic [7:0] luma(input logic [31:0] px);
    logic [15:0] s;
    begin
      s = 16'(54 * px[7:0]) + 16'(183 * px[15:8]) + 16'(18 * px[23:16]);
      luma = s[15:8];
    end
  endfunction

  function automatic logic [7:0] adiff(input logic [7:0] a, input logic [7:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

endpackage

// ===== rtl/deaa_ram.sv =====
module deaa_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/deaa_div.sv =====
module deaa_div import deaa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] num,
  input  logic [9:0]  den,
  output logic        busy,
  output logic [17:0] quo
);

  logic [17:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [10:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial = {rem_r, q_r[17]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 5'd18;
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = 10'(trial - {1'b0, den});
        q_nxt = {q_r[16:0], 1'b1};
      end else begin
        rem_nxt = trial[9:0];
        q_nxt = {q_r[16:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (cnt_r != 5'd0);
  assign quo = q_r;

endmodule

// ===== rtl/directional_edge_antialias_filter_unit.sv =====
// A transfer returns to idle after its read and calc states when no result is due or the
// pixel lies on the frame border; else one shared 18-step serial divider computes the edge
// strength and, when it exceeds the threshold, blurs the pixel channel by channel.
// A result enters the output register at the end of its work and the next pixel is accepted
// while it waits; work stalls only when a second result is ready before the first leaves.
// Reset restores the default registers and clears window, position and pending count.
module directional_edge_antialias_filter_unit import deaa_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // frame_end
  output logic [31:0] out_tdata,  // red_out, green_out, blue_out, alpha_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = CW + 1;

  logic [11:0] fw_r, fh_r;
  logic [7:0]  thr_r;
  logic [8:0]  sub_r;
  logic [CW-1:0] wl, col_r, col_nxt, ccur, ocol;
  logic [RW-1:0] hl, row_r, row_nxt, rcur, orow;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [31:0] win_r [9];
  logic [31:0] win_nxt [9];
  state_t st_r, st_nxt;
  logic        drain_r;
  logic [31:0] px_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;
  logic        emit_r, emit_nxt;
  logic [31:0] l1_q, l2_q;
  logic        we;

  logic [31:0] res_r, res_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic        olast_r, olast_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        run_r, run_nxt;
  logic [31:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [7:0]  wt_r, wt_nxt;
  logic        dstart;
  logic [17:0] dnum;
  logic [9:0]  dden;
  logic        dbusy;
  logic [17:0] dquo;

  logic [7:0] lc, lt, lb, ll, lr, mx, mn, strength;
  logic [7:0] cc, a1, a2;
  logic [16:0] gprod;
  logic [8:0]  gain;
  logic        border;
  logic        last_px;
  logic        slot_free;

  always_comb begin
    if (fw_r < 12'd3) wl = CW'(3);
    else if (32'(fw_r) > MAX_WIDTH) wl = CW'(MAX_WIDTH);
    else wl = CW'(fw_r);
    if (fh_r < 12'd3) hl = RW'(3);
    else if (32'(fh_r) > MAX_HEIGHT) hl = RW'(MAX_HEIGHT);
    else hl = RW'(fh_r);
    ccur = (col_r >= wl) ? '0 : col_r;
    rcur = (row_r >= hl) ? '0 : row_r;
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 12'd640;
      fh_r <= 12'd480;
      thr_r <= 8'd42;
      sub_r <= 9'd192;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:     fw_r <= cfg_data;
        CFG_HEIGHT:    fh_r <= cfg_data;
        CFG_THRESHOLD: thr_r <= cfg_data[7:0];
        CFG_SUBPIXEL:  sub_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (st_r == ST_IDLE);
  assign we = (st_r == ST_READ);
  assign slot_free = !ov_r || out_tready;

  deaa_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_line1 (
    .clk(clk), .we(we), .waddr(c_r[AW-1:0]), .wdata(px_r),
    .raddr(ccur[AW-1:0]), .rdata(l1_q));
  deaa_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_line2 (
    .clk(clk), .we(we), .waddr(c_r[AW-1:0]), .wdata(l1_q),
    .raddr(ccur[AW-1:0]), .rdata(l2_q));

  deaa_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo));

  always_comb begin
    lc = luma(win_r[4]);
    lt = luma(win_r[1]);
    lb = luma(win_r[7]);
    ll = luma(win_r[3]);
    lr = luma(win_r[5]);
    mx = lc; mn = lc;
    if (lt > mx) mx = lt;
    if (lb > mx) mx = lb;
    if (ll > mx) mx = ll;
    if (lr > mx) mx = lr;
    if (lt < mn) mn = lt;
    if (lb < mn) mn = lb;
    if (ll < mn) mn = ll;
    if (lr < mn) mn = lr;
    if (mx == 8'd0) strength = '0;
    else if (dquo[17:8] != '0) strength = 8'd255;
    else strength = dquo[7:0];
    gain = (sub_r > 9'd256) ? 9'd256 : sub_r;
    gprod = 17'(strength) * 17'(gain);
    ocol = (c_r == '0) ? wl - 1'b1 : c_r - 1'b1;
    if (c_r == '0) orow = (r_r == '0) ? hl - 1'b1 : r_r - 1'b1;
    else orow = r_r;
    if (c_r == '0) orow = (orow == '0) ? hl - 1'b1 : orow - 1'b1;
    else orow = (r_r == '0) ? hl - 1'b1 : r_r - 1'b1;
    border = (ocol == '0) || (ocol == wl - 1'b1) || (orow == '0) || (orow == hl - 1'b1);
    last_px = (orow == hl - 1'b1) && (ocol == wl - 1'b1);
  end

  always_comb begin
    cc = win_r[4][8*ch_r +: 8];
    a1 = n1_r[8*ch_r +: 8];
    a2 = n2_r[8*ch_r +: 8];
    if (st_r == ST_CALC) dnum = {2'b0, mx - mn, 8'd0};
    else dnum = {2'b0, cc, 8'd0} + 18'(wt_r) * (18'(a1) + 18'(a2));
    if (st_r == ST_DIV) dden = 10'd256 + {1'b0, wt_r, 1'b0};
    else dden = {2'b0, mx};
  end

  always_comb begin
    st_nxt = st_r;
    col_nxt = col_r;
    row_nxt = row_r;
    pend_nxt = pend_r;
    emit_nxt = emit_r;
    for (int i = 0; i < 9; i++) win_nxt[i] = win_r[i];
    res_nxt = res_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;
    ov_nxt = ov_r;
    ch_nxt = ch_r;
    run_nxt = run_r;
    n1_nxt = n1_r;
    n2_nxt = n2_r;
    wt_nxt = wt_r;
    dstart = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid && !(in_tuser && pend_r == '0)) st_nxt = ST_READ;
      end
      ST_READ: begin
        for (int r = 0; r < 3; r++) begin
          win_nxt[r*3] = win_r[r*3+1];
          win_nxt[r*3+1] = win_r[r*3+2];
        end
        win_nxt[2] = l2_q;
        win_nxt[5] = l1_q;
        win_nxt[8] = px_r;
        if (drain_r) begin
          emit_nxt = 1'b1;
          pend_nxt = pend_r - 1'b1;
        end else if (pend_r >= PW'(wl) + 1'b1) begin
          emit_nxt = 1'b1;
        end else begin
          emit_nxt = 1'b0;
          pend_nxt = pend_r + 1'b1;
        end
        if (CW'(c_r + 1'b1) >= wl) begin
          col_nxt = '0;
          row_nxt = (RW'(r_r + 1'b1) >= hl) ? '0 : RW'(r_r + 1'b1);
        end else begin
          col_nxt = CW'(c_r + 1'b1);
          row_nxt = r_r;
        end
        if (drain_r && pend_r == PW'(1)) begin
          col_nxt = '0;
          row_nxt = '0;
        end
        st_nxt = ST_CALC;
      end
      ST_CALC: begin
        res_nxt = win_r[4];
        if (adiff(lt, lb) > adiff(ll, lr)) begin
          n1_nxt = win_r[3]; n2_nxt = win_r[5];
        end else begin
          n1_nxt = win_r[1]; n2_nxt = win_r[7];
        end
        if (!emit_r) begin
          st_nxt = ST_IDLE;
        end else if (border) begin
          if (slot_free) begin
            odata_nxt = win_r[4];
            olast_nxt = last_px;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
        end else begin
          dstart = 1'b1;
          st_nxt = ST_STRENGTH;
        end
      end
      ST_STRENGTH: begin
        if (!dbusy) begin
          if (strength > thr_r) begin
            wt_nxt = gprod[15:8];
            ch_nxt = 2'd0;
            run_nxt = 1'b0;
            st_nxt = ST_DIV;
          end else if (slot_free) begin
            odata_nxt = win_r[4];
            olast_nxt = last_px;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (!run_r) begin
          dstart = 1'b1;
          run_nxt = 1'b1;
        end else if (!dbusy) begin
          res_nxt[8*ch_r +: 8] = dquo[7:0];
          if (ch_r != 2'd2) begin
            ch_nxt = ch_r + 2'd1;
            run_nxt = 1'b0;
          end else if (slot_free) begin
            odata_nxt = res_nxt;
            olast_nxt = last_px;
            ov_nxt = 1'b1;
            run_nxt = 1'b0;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      col_r <= '0;
      row_r <= '0;
      pend_r <= '0;
      ov_r <= 1'b0;
      emit_r <= 1'b0;
      run_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
      emit_r <= emit_nxt;
      run_r <= run_nxt;
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
    if (st_r == ST_IDLE) begin
      drain_r <= in_tuser;
      px_r <= in_tuser ? '0 : in_tdata;
      c_r <= ccur;
      r_r <= rcur;
    end
    res_r <= res_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ch_r <= ch_nxt;
    n1_r <= n1_nxt;
    n2_r <= n2_nxt;
    wt_r <= wt_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

endmodule

// ===== verif/deaa_checker.sv =====
`timescale 1ns / 1ps

module deaa_checker import deaa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        out_tlast,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } pixel_out_t;

  pixel_out_t pending_pixels[$];

  logic [11:0] width_reg, height_reg;
  logic [7:0]  thresh_reg;
  logic [8:0]  gain_reg;
  logic [31:0] row1_store[2048];
  logic [31:0] row2_store[2048];
  logic [31:0] win[9];
  int unsigned col_pos, row_pos, backlog;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 3) return 3;
    return (v > 2048) ? 2048 : v;
  endfunction

  function automatic int unsigned luma8(logic [31:0] p);
    return (54 * p[7:0] + 183 * p[15:8] + 18 * p[23:16]) >> 8;
  endfunction

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void filter_pixel(logic drain, logic [31:0] px_in);
    int unsigned w, h, col, ocol, orow, mx, mn, strength, wt, k, num;
    int unsigned lum[5];
    logic [31:0] px, c, res, n1, n2;
    logic emit, border, horiz;
    pixel_out_t r;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (drain && backlog == 0) return;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    px = drain ? 32'd0 : px_in;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = row2_store[col];
    win[5] = row1_store[col];
    win[8] = px;
    row2_store[col] = row1_store[col];
    row1_store[col] = px;
    if (drain) begin
      emit = 1;
      backlog--;
    end else if (backlog >= w + 1) begin
      emit = 1;
    end else begin
      emit = 0;
      backlog++;
    end
    ocol = (col == 0) ? w - 1 : col - 1;
    orow = (row_pos + h - 1 - ((col == 0) ? 1 : 0)) % h;
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end
    if (drain && backlog == 0) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (!emit) return;
    c = win[4];
    res = c;
    border = (ocol == 0) || (ocol == w - 1) || (orow == 0) || (orow == h - 1);
    if (!border) begin
      lum[0] = luma8(c);
      lum[1] = luma8(win[1]);
      lum[2] = luma8(win[7]);
      lum[3] = luma8(win[3]);
      lum[4] = luma8(win[5]);
      mx = lum[0];
      mn = lum[0];
      for (int i = 1; i < 5; i++) begin
        if (lum[i] > mx) mx = lum[i];
        if (lum[i] < mn) mn = lum[i];
      end
      strength = 0;
      if (mx != 0) begin
        strength = (256 * (mx - mn)) / mx;
        if (strength > 255) strength = 255;
      end
      if (strength > thresh_reg) begin
        wt = (strength * ((gain_reg > 256) ? 256 : gain_reg)) >> 8;
        horiz = abs_diff(lum[1], lum[2]) > abs_diff(lum[3], lum[4]);
        n1 = horiz ? win[3] : win[1];
        n2 = horiz ? win[5] : win[7];
        for (k = 0; k < 3; k++) begin
          num = 256 * c[8*k +: 8] + wt * (n1[8*k +: 8] + n2[8*k +: 8]);
          res[8*k +: 8] = 8'(num / (256 + 2 * wt));
        end
      end
    end
    r.red = res[7:0];
    r.green = res[15:8];
    r.blue = res[23:16];
    r.alpha = res[31:24];
    r.frame_end = (orow == h - 1) && (ocol == w - 1);
    pending_pixels.push_back(r);
  endfunction

  always @(posedge clk) begin
    pixel_out_t e;
    if (!rst_n) begin
      width_reg <= 12'd640;
      height_reg <= 12'd480;
      thresh_reg <= 8'd42;
      gain_reg <= 9'd192;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < 2048; i++) begin
        row1_store[i] = '0;
        row2_store[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      backlog = 0;
      pending_pixels.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("output transfer with no expected pixel");
          errors <= errors + 1;
        end else begin
          e = pending_pixels.pop_front();
          if (out_tdata[7:0] !== e.red || out_tdata[15:8] !== e.green ||
              out_tdata[23:16] !== e.blue || out_tdata[31:24] !== e.alpha ||
              out_tlast !== e.frame_end) begin
            errors <= errors + 1;
            if (out_tdata[7:0] !== e.red)
              $error("red_out expected %0d actual %0d", e.red, out_tdata[7:0]);
            if (out_tdata[15:8] !== e.green)
              $error("green_out expected %0d actual %0d", e.green, out_tdata[15:8]);
            if (out_tdata[23:16] !== e.blue)
              $error("blue_out expected %0d actual %0d", e.blue, out_tdata[23:16]);
            if (out_tdata[31:24] !== e.alpha)
              $error("alpha_out expected %0d actual %0d", e.alpha, out_tdata[31:24]);
            if (out_tlast !== e.frame_end)
              $error("frame_end expected %0d actual %0d", e.frame_end, out_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:     width_reg <= cfg_data;
          CFG_HEIGHT:    height_reg <= cfg_data;
          CFG_THRESHOLD: thresh_reg <= cfg_data[7:0];
          CFG_SUBPIXEL:  gain_reg <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) filter_pixel(in_tuser, in_tdata);
      outstanding <= pending_pixels.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import deaa_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [31:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  int          errors, outstanding;
  int          idle_cycles;
  int          stall_left;
  bit          quiet;
  int unsigned cur_width, backlog;

  directional_edge_antialias_filter_unit DUT (.*);

  deaa_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_item(logic drain, logic [31:0] px);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= drain;
    in_tdata <= drain ? 32'($urandom) : px;
    do @(posedge clk); while (!in_tready);
    if (drain) begin
      if (backlog > 0) backlog--;
    end else if (backlog < cur_width + 1) begin
      backlog++;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {8'($urandom), 24'h0};
      2: return {8'($urandom), 24'hFFFFFF};
      default: begin
        v = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 1) * 255);
        return {8'($urandom), v, v, v};
      end
    endcase
  endfunction

  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0 || (out_tvalid && !out_tready)) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic flush_frame();
    while (backlog > 0) put_item(1'b1, '0);
    put_item(1'b1, '0);
    settle();
  endtask

  task automatic set_mode(logic [11:0] w, logic [11:0] h, logic [7:0] thr, logic [8:0] sub);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_THRESHOLD, 12'(thr));
    write_reg(CFG_SUBPIXEL, 12'(sub));
    cfg_valid <= 1'b0;
    cur_width = (w < 3) ? 3 : ((w > 2048) ? 2048 : w);
  endtask

  task automatic run_frame(int unsigned npix);
    int unsigned nd;
    if ($urandom_range(0, 3) == 0) put_item(1'b1, '0);
    for (int unsigned i = 0; i < npix; i++) begin
      if (backlog > 1 && $urandom_range(0, 99) < 4) begin
        nd = $urandom_range(1, backlog - 1);
        repeat (nd) put_item(1'b1, '0);
      end
      put_item(1'b0, rand_pixel());
    end
    flush_frame();
  endtask

  logic [31:0] corner_pixels[18] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFF000000, 32'h00FFFFFF, 32'h000000FF, 32'h0000FF00,
    32'h00FF0000, 32'hFFFFFFFF, 32'h00000000, 32'h80FFFFFF, 32'h00000000, 32'hFF808080,
    32'h01010101, 32'hFEFEFEFE, 32'h7F7F7F7F, 32'h00000000, 32'hFFFFFFFF, 32'h00000000
  };

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    quiet = 1'b0;
    backlog = 0;
    cur_width = 640;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(12'd3, 12'd3, 8'd0, 9'd256);
    put_item(1'b1, '0);
    foreach (corner_pixels[i]) put_item(1'b0, corner_pixels[i]);
    repeat (2) put_item(1'b1, '0);
    put_item(1'b0, 32'hFFFFFFFF);
    flush_frame();

    set_mode(12'd0, 12'd1, 8'd255, 9'd511);
    run_frame(30);
    set_mode(12'd2, 12'd2, 8'd0, 9'd0);
    run_frame(30);

    for (int p = 0; p < 8; p++) begin
      quiet = (p % 3 == 2);
      set_mode(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)),
               8'($urandom_range(0, 60)), 9'($urandom_range(0, 300)));
      run_frame($urandom_range(60, 110));
    end
    quiet = 1'b0;

    set_mode(12'd3, 12'd2048, 8'd1, 9'd256);
    run_frame(40);
    set_mode(12'd4095, 12'd4095, 8'd10, 9'd128);
    run_frame(20);

    settle();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
